[design/sadq_pkg.sv]
// ----------------------------------------------------------------------------
// sadq_pkg: shared types and constants of the sorted alarm deadline queue
// Item layouts, status codes and field widths used by the queue.
// ----------------------------------------------------------------------------
package sadq_pkg;

  localparam int TIME_W      = 32;
  localparam int DELAY_W     = 16;
  localparam int TAG_W       = 8;
  localparam int DL_W        = 33;
  localparam int WAIT_W      = 16;
  localparam int OCC_W       = 5;
  localparam int DEPTH_DEF   = 16;

  localparam logic [WAIT_W-1:0] WAIT_MAX   = '1;
  localparam logic [WAIT_W-1:0] WAIT_EMPTY = WAIT_W'(1);

  // operation carried by an input item
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } sadq_op_t;

  // outcome reported with each result item
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_POPPED   = 2'd2,
    ST_EMPTY    = 2'd3
  } sadq_status_t;

  typedef struct packed {
    sadq_op_t           op;
    logic [TIME_W-1:0]  now;
    logic [DELAY_W-1:0] delay_seconds;
    logic [TAG_W-1:0]   tag;
  } sadq_in_t;

  typedef struct packed {
    sadq_status_t       status;
    logic [TAG_W-1:0]   out_tag;
    logic [DL_W-1:0]    out_deadline;
    logic [WAIT_W-1:0]  wait_seconds;
    logic [OCC_W-1:0]   occupancy;
  } sadq_out_t;

  // one stored alarm
  typedef struct packed {
    logic [DL_W-1:0]  deadline;
    logic [TAG_W-1:0] tag;
  } sadq_entry_t;

endpackage

[design/sorted_alarm_deadline_queue.sv]
// ----------------------------------------------------------------------------
// sorted_alarm_deadline_queue: alarms kept in ascending deadline order
// An insert moves up, one by one, each stored entry that is not earlier than the
//   new alarm; a pop reads the head, then shifts the rest down one slot; a full
//   insert or an empty pop goes straight to the result.
// Throughput: one item at a time; busy drops in the cycle of the result strobe.
//   The entry memory, one read and one write per step, sets the pace.
// Reset clears the sequencer and the entry count; the memory is not cleared.
// Results appear for one cycle on out_valid; the receiver cannot stall.
// ----------------------------------------------------------------------------
module sorted_alarm_deadline_queue #(
  parameter int QUEUE_DEPTH = sadq_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sadq_pkg::sadq_in_t  in_item,
  output logic               out_valid,
  output sadq_pkg::sadq_out_t out_item
);
  import sadq_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_INS_RD   = 9'b000000010,
    S_INS_CMP  = 9'b000000100,
    S_INS_PUT  = 9'b000001000,
    S_POP_RD   = 9'b000010000,
    S_POP_HEAD = 9'b000100000,
    S_SH_RD    = 9'b001000000,
    S_SH_WR    = 9'b010000000,
    S_DONE     = 9'b100000000
  } sadq_state_t;

  sadq_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  sadq_entry_t new_r, new_nxt;
  sadq_out_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;

  // entry memory, one read and one write port shared by all steps
  sadq_entry_t mem [QUEUE_DEPTH];
  sadq_entry_t rd_data_r;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  sadq_entry_t wr_data;
  logic wr_en;

  logic [DL_W:0]     wait_diff;
  logic [WAIT_W-1:0] wait_val;
  logic [31:0]       count_ext;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = res_r;
  assign count_ext = 32'(count_nxt);

  // remaining wait of the head entry, saturated
  assign wait_diff = {1'b0, rd_data_r.deadline} - (DL_W + 1)'(now_r);
  always_comb begin
    if (rd_data_r.deadline <= DL_W'(now_r)) begin
      wait_val = '0;
    end else if (wait_diff > (DL_W + 1)'(WAIT_MAX)) begin
      wait_val = WAIT_MAX;
    end else begin
      wait_val = wait_diff[WAIT_W-1:0];
    end
  end

  // store writes and registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    now_nxt       = now_r;
    new_nxt       = new_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    rd_addr       = idx_r - IDX_W'(1);
    wr_addr       = idx_r;
    wr_data       = new_r;
    wr_en         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          now_nxt              = in_item.now;
          new_nxt.deadline     = DL_W'(in_item.now) + DL_W'(in_item.delay_seconds);
          new_nxt.tag          = in_item.tag;
          res_nxt.out_tag      = '0;
          res_nxt.wait_seconds = '0;
          res_nxt.out_deadline = DL_W'(in_item.now) + DL_W'(in_item.delay_seconds);
          if (in_item.op == OP_INSERT) begin
            if (count_r == CNT_W'(QUEUE_DEPTH)) begin
              res_nxt.status = ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              res_nxt.status = ST_INSERTED;
              idx_nxt        = count_r[IDX_W-1:0];
              state_nxt      = (count_r == '0) ? S_INS_PUT : S_INS_RD;
            end
          end else if (count_r == '0) begin
            res_nxt.status       = ST_EMPTY;
            res_nxt.out_deadline = '0;
            res_nxt.wait_seconds = WAIT_EMPTY;
            state_nxt            = S_DONE;
          end else begin
            res_nxt.status = ST_POPPED;
            state_nxt      = S_POP_RD;
          end
        end
      end
      // fetch the entry below the open slot
      S_INS_RD: begin
        state_nxt = S_INS_CMP;
      end
      // move it up if it is not earlier than the new alarm, else drop in here
      S_INS_CMP: begin
        if (rd_data_r.deadline >= new_r.deadline) begin
          wr_en     = 1'b1;
          wr_data   = rd_data_r;
          idx_nxt   = idx_r - IDX_W'(1);
          state_nxt = (idx_r == IDX_W'(1)) ? S_INS_PUT : S_INS_RD;
        end else begin
          state_nxt = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        wr_en     = 1'b1;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_DONE;
      end
      // read the head
      S_POP_RD: begin
        rd_addr   = '0;
        state_nxt = S_POP_HEAD;
      end
      S_POP_HEAD: begin
        res_nxt.out_tag      = rd_data_r.tag;
        res_nxt.out_deadline = rd_data_r.deadline;
        res_nxt.wait_seconds = wait_val;
        idx_nxt              = IDX_W'(1);
        if (count_r == CNT_W'(1)) begin
          count_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SH_RD;
        end
      end
      // shift the remaining entries down one slot
      S_SH_RD: begin
        rd_addr   = idx_r;
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r - IDX_W'(1);
        wr_data = rd_data_r;
        if (CNT_W'(idx_r) == count_r - CNT_W'(1)) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_SH_RD;
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (state_r == S_DONE) begin
      res_nxt.occupancy = count_ext[OCC_W-1:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    now_r <= now_nxt;
    new_r <= new_nxt;
    res_r <= res_nxt;
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sorted alarm deadline queue
// Feeds insert and pop items through the start/busy handshake, predicts each
// result with a shadow copy of the sorted queue and checks every strobed
// result field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  import sadq_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int RANDOM_CNT = 850;
  localparam int DRAIN_CYC  = 2 * DEPTH + 8;

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  sadq_in_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  sadq_out_t out_item;

  // requests waiting for the driver, results waiting for the checker
  sadq_in_t  alarm_requests[$];
  sadq_out_t outcome_q[$];

  // shadow copy of the queue contents
  logic [DL_W-1:0]  shadow_deadline[DEPTH];
  logic [TAG_W-1:0] shadow_tag[DEPTH];
  int               shadow_count = 0;

  int  error_count  = 0;
  int  issued_count = 0;
  int  insert_cnt   = 0;
  int  full_cnt     = 0;
  int  pop_cnt      = 0;
  int  empty_cnt    = 0;
  int  peak_occ     = 0;
  sadq_out_t want;

  sorted_alarm_deadline_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Compute the result of one accepted item and advance the shadow queue.
  function automatic sadq_out_t queue_outcome(sadq_in_t req);
    sadq_out_t         res;
    logic [DL_W-1:0]   dl;
    logic [DL_W-1:0]   gap;
    int                pos;
    res = '0;
    if (req.op == OP_INSERT) begin
      dl = DL_W'(req.now) + DL_W'(req.delay_seconds);
      res.out_deadline = dl;
      if (shadow_count >= DEPTH) begin
        res.status = ST_FULL;
        full_cnt++;
      end else begin
        // new alarm goes ahead of the first entry with an equal or later deadline
        pos = shadow_count;
        for (int i = shadow_count - 1; i >= 0; i--) begin
          if (shadow_deadline[i] >= dl) pos = i;
        end
        for (int i = shadow_count; i > pos; i--) begin
          shadow_deadline[i] = shadow_deadline[i-1];
          shadow_tag[i]      = shadow_tag[i-1];
        end
        shadow_deadline[pos] = dl;
        shadow_tag[pos]      = req.tag;
        shadow_count++;
        res.status = ST_INSERTED;
        insert_cnt++;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status       = ST_EMPTY;
        res.wait_seconds = WAIT_EMPTY;
        empty_cnt++;
      end else begin
        res.status       = ST_POPPED;
        res.out_tag      = shadow_tag[0];
        res.out_deadline = shadow_deadline[0];
        if (shadow_deadline[0] <= DL_W'(req.now)) begin
          res.wait_seconds = '0;
        end else begin
          gap = shadow_deadline[0] - DL_W'(req.now);
          res.wait_seconds = (gap > DL_W'(WAIT_MAX)) ? WAIT_MAX : gap[WAIT_W-1:0];
        end
        for (int i = 1; i < shadow_count; i++) begin
          shadow_deadline[i-1] = shadow_deadline[i];
          shadow_tag[i-1]      = shadow_tag[i];
        end
        shadow_count--;
        pop_cnt++;
      end
    end
    res.occupancy = OCC_W'(shadow_count);
    if (shadow_count > peak_occ) peak_occ = shadow_count;
    return res;
  endfunction

  task automatic add_request(sadq_op_t op, logic [TIME_W-1:0] now,
                             logic [DELAY_W-1:0] delay, logic [TAG_W-1:0] tag);
    sadq_in_t req;
    req.op            = op;
    req.now           = now;
    req.delay_seconds = delay;
    req.tag           = tag;
    alarm_requests.push_back(req);
  endtask

  task automatic check_field(string field, logic [DL_W-1:0] exp_v, logic [DL_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, exp_v, got_v);
      error_count++;
    end
  endtask

  // Driver: predict on acceptance, then present the next item or take a gap.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        outcome_q.push_back(queue_outcome(in_item));
      end
      if (!(start && busy)) begin
        if (alarm_requests.size() == 0 ||
            (($urandom_range(0, 99) < 32) && !(issued_count >= 400 && issued_count < 560))) begin
          start <= 1'b0;
        end else begin
          start   <= 1'b1;
          in_item <= alarm_requests.pop_front();
          issued_count++;
        end
      end
    end
  end

  // Monitor: match each strobed result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, got %p", $time, out_item);
        error_count++;
      end else begin
        want = outcome_q.pop_front();
        check_field("status", DL_W'(want.status), DL_W'(out_item.status));
        check_field("out_tag", DL_W'(want.out_tag), DL_W'(out_item.out_tag));
        check_field("out_deadline", want.out_deadline, out_item.out_deadline);
        check_field("wait_seconds", DL_W'(want.wait_seconds), DL_W'(out_item.wait_seconds));
        check_field("occupancy", DL_W'(want.occupancy), DL_W'(out_item.occupancy));
      end
    end
  end

  // Build the stimulus, release reset, then wait for the queue to drain.
  initial begin
    logic [TIME_W-1:0]  base_time;
    logic [TIME_W-1:0]  now_v;
    logic [DELAY_W-1:0] delay_v;
    bit                 fill_phase;
    int                 pick;

    // empty pop, extreme deadlines, equal deadlines
    add_request(OP_POP, 32'h0, 16'h0, 8'h0);
    add_request(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    add_request(OP_INSERT, 32'h0, 16'h0, 8'h00);
    add_request(OP_INSERT, 32'h0, 16'h0, 8'h5A);
    // fill to capacity, then overflow
    for (int i = 0; i < DEPTH - 3; i++) begin
      add_request(OP_INSERT, TIME_W'(32'h0010_0000 * (i + 1)), DELAY_W'(i * 7), TAG_W'(8'h10 + i));
    end
    add_request(OP_INSERT, 32'h8000_0000, 16'h8000, 8'hA5);
    // deadline equal to now, saturated wait, deadline long passed
    add_request(OP_POP, 32'h0, 16'hFFFF, 8'hFF);
    add_request(OP_POP, 32'h0, 16'h0, 8'h0);
    add_request(OP_POP, 32'h0, 16'h1234, 8'h3C);
    add_request(OP_POP, 32'hFFFF_FFFF, 16'h0, 8'h0);

    // random traffic in alternating fill and drain phases around a moving clock
    base_time = $urandom;
    for (int n = 0; n < RANDOM_CNT; n++) begin
      fill_phase = ((n / 48) % 2) == 0;
      base_time  = base_time + $urandom_range(0, 50);
      if ($urandom_range(0, 15) == 0) base_time = $urandom;
      pick = $urandom_range(0, 9);
      if (pick == 0) now_v = $urandom;
      else if (pick == 1) now_v = base_time - $urandom_range(0, 200000);
      else now_v = base_time + $urandom_range(0, 2000);
      pick = $urandom_range(0, 9);
      if (pick < 4) delay_v = DELAY_W'($urandom_range(0, 7));
      else if (pick == 4) delay_v = ($urandom_range(0, 1) == 0) ? 16'h0 : 16'hFFFF;
      else delay_v = DELAY_W'($urandom);
      add_request(($urandom_range(0, 99) < (fill_phase ? 70 : 30)) ? OP_INSERT : OP_POP,
                  now_v, delay_v, TAG_W'($urandom));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (alarm_requests.size() != 0 || start) @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Ran %0d items: %0d inserts, %0d rejected on full, %0d pops, %0d on empty",
             issued_count, insert_cnt, full_cnt, pop_cnt, empty_cnt);
    $display("Queue reached %0d of %0d entries; %0d field mismatches",
             peak_occ, DEPTH, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Bound the run in case the block hangs.
  initial begin
    #5ms;
    $display("%0t: run did not finish in time", $time);
    $display("FAIL");
    $finish;
  end

endmodule

[filelist.f]
design/sadq_pkg.sv
design/sorted_alarm_deadline_queue.sv
bench/tb.sv
